/* hw/rtl/bba_pkg.sv */
// Shared types, codes and constants of the block bitmap allocator.
// No dependencies; imported by every module of the block but bba_ram.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Field and register widths
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BLK_W     = 12;
  localparam int unsigned ST_W      = 3;

  // Bitmap word organization: 32 blocks per memory word
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WORD_SH = 5;

  // Width of block-number arithmetic (data start, limit up to 8191)
  localparam int unsigned CMP_W = 17;

  // Boot block, super block, one extra inode block and one extra bitmap block
  localparam int unsigned FIXED_META_BLOCKS = 2 + 1 + 1;

  // Parameter defaults
  localparam int unsigned MAX_BLOCKS_DEF       = 4096;
  localparam int unsigned BLOCK_BYTES_DEF      = 1024;
  localparam int unsigned INODES_PER_BLOCK_DEF = 16;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_BLOCKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT  = 2'd2;

  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd1000;
  localparam logic [CFG_W-1:0] LOG_BLOCKS_RST   = 13'd30;
  localparam logic [CFG_W-1:0] INODE_COUNT_RST  = 13'd200;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_METADATA     = 3'd2,
    ST_RANGE        = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic div_step;
    logic decide;
    logic scan;
    logic free_chk;
  } bba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic fin;
    logic is_free;
  } bba_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/block_bitmap_allocator.sv */
// Top level of the block bitmap allocator: controller, datapath and bitmap RAM.
// Depends on bba_pkg, bba_ctrl, bba_dp, bba_ram.
`timescale 1ns / 1ps
`default_nettype none

// First-fit disk block allocator over a used/free bitmap.
// Command channel: a beat is taken when start_i is high and busy_o is low.
// action_i = 0 allocates the lowest free data block, action_i = 1 frees
// block_number_i. Each command gives one result beat: done_o is high for one
// cycle with granted_block_o and status_o; the receiver cannot stall it.
// Configuration: cfg_valid_i/cfg_ready_o write beats (ready always high) set
// total_blocks, log_blocks and inode_count; write them only while idle.
// Sequence: the accepting edge registers the inode and bitmap area sizes
// (constant reciprocal multiplies), a divide state follows and a decide state
// checks the request. A metadata or range answer ends there, as does a
// no-space answer when the data start reaches the limit; a free spends one
// more state on its bitmap word; an allocate reads one 32-bit bitmap word a
// cycle through the RAM read port, up to MAX_BLOCKS/32 words in all.
// The next command may be accepted at the edge that ends the done_o cycle.
// Reset: registers return to 1000/30/200 and a clearing pass writes zero to
// every bitmap word, one word a cycle (MAX_BLOCKS/32 = 128 words by
// default); busy_o stays high until it ends.
module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS       = MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES      = BLOCK_BYTES_DEF,
  parameter int unsigned INODES_PER_BLOCK = INODES_PER_BLOCK_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 action_i,
  input  wire logic [BLK_W-1:0]     block_number_i,
  output logic                      done_o,
  output logic      [BLK_W-1:0]     granted_block_o,
  output logic      [ST_W-1:0]      status_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  bba_cmd_t          cmd;
  bba_sts_t          sts;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Configuration beats are always taken
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  bba_dp #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .BLOCK_BYTES      (BLOCK_BYTES),
    .INODES_PER_BLOCK (INODES_PER_BLOCK)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .block_number_i  (block_number_i),
    .granted_block_o (granted_block_o),
    .status_o        (status_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // A failed command never grants a block
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (granted_block_o == '0))
    else $error("nonzero granted block on a failed command");

  // A free command never grants a block: checked where its decide or free step ends
  a_free_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i) |=>
      ##2 ((granted_block_o == '0) || !done_o) ##1 ((granted_block_o == '0) || !done_o))
    else $error("free command reported a granted block");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting a command");

  // Result strobe lasts one cycle and comes with the block idle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && !$past(done_o)))
    else $error("result strobe longer than one cycle or while busy");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_OK) || (status_o == ST_NO_SPACE)
             || (status_o == ST_METADATA) || (status_o == ST_RANGE)
             || (status_o == ST_ALREADY_FREE)))
    else $error("undefined status code on result");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bba_cdiv.sv */
// Constant divider by reciprocal multiplication, quotient registered on load.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_cdiv
  import bba_pkg::*;
#(
  parameter int unsigned DIVISOR = INODES_PER_BLOCK_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic [CFG_W-1:0] dividend_i,
  output logic      [CFG_W-1:0] quotient_o
);

  // A shift of CFG_W plus ceil(log2 DIVISOR) keeps the rounded-up reciprocal
  // exact for every dividend below 2^CFG_W
  localparam int unsigned     SH     = CFG_W + $clog2(DIVISOR);
  localparam int unsigned     PROD_W = SH + CFG_W;
  localparam longint unsigned RECIP  =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PROD_W-1:0] prod_c;
  logic [CFG_W-1:0]  quot_q;

  // Multiply by the reciprocal; the quotient sits above the shift
  assign prod_c = PROD_W'(dividend_i) * PROD_W'(RECIP);

  // Hold the quotient for the rest of the command
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q <= prod_c[SH +: CFG_W];
    end
  end

  assign quotient_o = quot_q;

endmodule

`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
// Controller of the block bitmap allocator: sequences clear, divide, decide,
// scan and free steps. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire bba_sts_t sts_i,
  output bba_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_DECIDE,
    S_SCAN,
    S_FREE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIVIDE;
          busy_d     = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.fin) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
          done_d  = 1'b1;
        end else if (sts_i.is_free) begin
          state_d = S_FREE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.fin) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
          done_d  = 1'b1;
        end
      end
      S_FREE: begin
        cmd_o.free_chk = 1'b1;
        state_d        = S_IDLE;
        busy_d         = 1'b0;
        done_d         = 1'b1;
      end
      default: begin
        state_d = S_CLEAR;
        busy_d  = 1'b1;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/bba_dp.sv */
// Datapath of the block bitmap allocator: registers, data-start dividers,
// bitmap word scan and free check. Depends on bba_pkg and bba_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS       = MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES      = BLOCK_BYTES_DEF,
  parameter int unsigned INODES_PER_BLOCK = INODES_PER_BLOCK_DEF,
  localparam int unsigned WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W,
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bba_cmd_t             cmd_i,
  output bba_sts_t                  sts_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 action_i,
  input  wire logic [BLK_W-1:0]     block_number_i,
  output logic      [BLK_W-1:0]     granted_block_o,
  output logic      [ST_W-1:0]      status_o,
  output logic                      ram_we_o,
  output logic      [AW-1:0]        ram_waddr_o,
  output logic      [WORD_W-1:0]    ram_wdata_o,
  output logic                      ram_re_o,
  output logic      [AW-1:0]        ram_raddr_o,
  input  wire logic [WORD_W-1:0]    ram_rdata_i
);

  localparam int unsigned OFF_W     = WORD_SH;

  // Lowest set bit of a bitmap word
  function automatic logic [OFF_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = OFF_W'(i);
      end
    end
    return idx;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] total_q, log_q, inode_q;

  // Item registers
  logic             action_q;
  logic [BLK_W-1:0] block_q;
  logic [CMP_W-1:0] limit_q;

  // Scan registers
  logic [AW-1:0]    clr_ptr_q;
  logic [AW-1:0]    rd_word_q;
  logic [AW-1:0]    chk_word_q;
  logic [AW-1:0]    start_word_q;
  logic [AW-1:0]    last_word_q;
  logic [OFF_W-1:0] lo_off_q;
  logic [OFF_W-1:0] hi_off_q;
  logic [OFF_W-1:0] free_off_q;

  // Result registers
  logic [BLK_W-1:0] granted_q;
  status_e          status_q;

  logic [CFG_W-1:0] inode_quot, total_quot;
  logic [CMP_W-1:0] start_c, lim_m1_c, blk_c, grant_c;
  logic [AW-1:0]    start_word_c, free_word_c;
  logic             decide_fin;
  status_e          decide_st;
  logic [WORD_W-1:0] mask_c, cand_c, wr_word_c;
  logic [OFF_W-1:0] hit_off_c;
  logic             hit_c, scan_fin;
  logic             free_used_c;

  // Constant dividers for the inode and bitmap area sizes
  bba_cdiv #(
    .DIVISOR (INODES_PER_BLOCK)
  ) u_inode_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .dividend_i (inode_q),
    .quotient_o (inode_quot)
  );

  bba_cdiv #(
    .DIVISOR (BLOCK_BYTES * 8)
  ) u_bitmap_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .dividend_i (total_q),
    .quotient_o (total_quot)
  );

  // First data block and range checks
  always_comb begin
    start_c      = CMP_W'(FIXED_META_BLOCKS) + CMP_W'(log_q)
                 + CMP_W'(inode_quot) + CMP_W'(total_quot);
    lim_m1_c     = limit_q - CMP_W'(1);
    blk_c        = CMP_W'(block_q);
    start_word_c = start_c[WORD_SH +: AW];
    free_word_c  = blk_c[WORD_SH +: AW];
    decide_fin   = 1'b0;
    decide_st    = ST_OK;
    if (!action_q) begin
      if (start_c >= limit_q) begin
        decide_fin = 1'b1;
        decide_st  = ST_NO_SPACE;
      end
    end else if (blk_c < start_c) begin
      decide_fin = 1'b1;
      decide_st  = ST_METADATA;
    end else if (blk_c >= limit_q) begin
      decide_fin = 1'b1;
      decide_st  = ST_RANGE;
    end
  end

  // Candidate free blocks in the word under check
  always_comb begin
    mask_c = '1;
    if (chk_word_q == start_word_q) begin
      mask_c = mask_c & ({WORD_W{1'b1}} << lo_off_q);
    end
    if (chk_word_q == last_word_q) begin
      mask_c = mask_c & ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi_off_q));
    end
    cand_c      = ~ram_rdata_i & mask_c;
    hit_c       = |cand_c;
    hit_off_c   = lowest_one(cand_c);
    scan_fin    = hit_c || (chk_word_q == last_word_q);
    grant_c     = CMP_W'({chk_word_q, hit_off_c});
    free_used_c = ram_rdata_i[free_off_q];
    wr_word_c   = cmd_i.scan ? (ram_rdata_i | (WORD_W'(1) << hit_off_c))
                             : (ram_rdata_i & ~(WORD_W'(1) << free_off_q));
  end

  // Memory port selection
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = chk_word_q;
    ram_wdata_o = wr_word_c;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_word_q;
    if (cmd_i.clear) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_ptr_q;
      ram_wdata_o = '0;
    end else if (cmd_i.scan) begin
      ram_we_o = hit_c;
      ram_re_o = 1'b1;
    end else if (cmd_i.free_chk) begin
      ram_we_o = free_used_c;
    end else if (cmd_i.decide && !decide_fin) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = action_q ? free_word_c : start_word_c;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.clr_done = cmd_i.clear && (clr_ptr_q == AW'(WORDS - 1));
    sts_o.div_done = cmd_i.div_step;
    sts_o.fin      = (cmd_i.decide && decide_fin) || (cmd_i.scan && scan_fin)
                   || cmd_i.free_chk;
    sts_o.is_free  = action_q;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_BLOCKS_RST;
      log_q   <= LOG_BLOCKS_RST;
      inode_q <= INODE_COUNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TOTAL_BLOCKS) begin
        total_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_LOG_BLOCKS) begin
        log_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_INODE_COUNT) begin
        inode_q <= cfg_data_i;
      end
    end
  end

  // Clear pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_ptr_q <= clr_ptr_q + AW'(1);
      end
    end
  end

  // Latch the item, set up and advance the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      block_q  <= block_number_i;
      limit_q  <= (CMP_W'(total_q) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                         : CMP_W'(total_q);
    end
    if (cmd_i.decide) begin
      start_word_q <= start_word_c;
      last_word_q  <= lim_m1_c[WORD_SH +: AW];
      lo_off_q     <= start_c[OFF_W-1:0];
      hi_off_q     <= lim_m1_c[OFF_W-1:0];
      free_off_q   <= block_q[OFF_W-1:0];
      chk_word_q   <= action_q ? free_word_c : start_word_c;
      rd_word_q    <= start_word_c + AW'(1);
    end else if (cmd_i.scan) begin
      chk_word_q <= rd_word_q;
      rd_word_q  <= rd_word_q + AW'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && decide_fin) begin
      granted_q <= '0;
      status_q  <= decide_st;
    end else if (cmd_i.scan && scan_fin) begin
      granted_q <= hit_c ? grant_c[BLK_W-1:0] : '0;
      status_q  <= hit_c ? ST_OK : ST_NO_SPACE;
    end else if (cmd_i.free_chk) begin
      granted_q <= '0;
      status_q  <= free_used_c ? ST_OK : ST_ALREADY_FREE;
    end
  end

  assign granted_block_o = granted_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire
